FILE: rtl/text_console_cell_writer_unit_defines.svh
// Assertion macros for the text console cell writer RTL (used by tccw_dp).
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define TCCW_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define TCCW_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tccw_pkg.sv
// Types and constants shared by the text console cell writer modules.
package tccw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned COLOUR_W    = 4;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0a;

  typedef enum logic [1:0] {
    FN_PUT   = 2'd0,
    FN_CLEAR = 2'd1,
    FN_READ  = 2'd2
  } func_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FG_COLOUR = 4'd0,
    REG_BG_COLOUR = 4'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SWP_INIT,
    SWP_CLEAR,
    SWP_SCROLL
  } sweep_mode_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_INIT_END,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        scrolled;
  } out_item_t;

  typedef struct packed {
    logic        accept;
    logic        exec_put;
    logic        sweep_start;
    sweep_mode_e sweep_mode;
    logic        sweep_step;
    logic        load_result;
    logic        from_sweep;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       scroll_need;
    logic       sweep_last;
    logic       out_free;
  } dp_status_t;

endpackage

FILE: rtl/tccw_ctrl.sv
// Command sequencer of the text console cell writer.
module tccw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tccw_pkg::dp_status_t  sts_i,
  output tccw_pkg::dp_cmd_t     cmd_o
);

  tccw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tccw_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.sweep_mode  = tccw_pkg::SWP_INIT;
    in_ready_o        = 1'b0;
    case (state_q)
      tccw_pkg::ST_INIT: begin
        // blank every cell after reset
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) state_d = tccw_pkg::ST_INIT_END;
      end
      tccw_pkg::ST_INIT_END: begin
        // let the last pending write land
        state_d = tccw_pkg::ST_IDLE;
      end
      tccw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = tccw_pkg::ST_EXEC;
        end
      end
      tccw_pkg::ST_EXEC: begin
        case (sts_i.func)
          tccw_pkg::FN_PUT: begin
            if (sts_i.scroll_need) begin
              cmd_o.exec_put    = 1'b1;
              cmd_o.sweep_start = 1'b1;
              cmd_o.sweep_mode  = tccw_pkg::SWP_SCROLL;
              state_d           = tccw_pkg::ST_SWEEP;
            end else if (sts_i.out_free) begin
              cmd_o.exec_put    = 1'b1;
              cmd_o.load_result = 1'b1;
              state_d           = tccw_pkg::ST_IDLE;
            end
          end
          tccw_pkg::FN_CLEAR: begin
            cmd_o.sweep_start = 1'b1;
            cmd_o.sweep_mode  = tccw_pkg::SWP_CLEAR;
            state_d           = tccw_pkg::ST_SWEEP;
          end
          default: begin
            // read, or a code that does nothing
            if (sts_i.out_free) begin
              cmd_o.load_result = 1'b1;
              state_d           = tccw_pkg::ST_IDLE;
            end
          end
        endcase
      end
      tccw_pkg::ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) state_d = tccw_pkg::ST_DONE;
      end
      tccw_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_result = 1'b1;
          cmd_o.from_sweep  = 1'b1;
          state_d           = tccw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tccw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/tccw_dp.sv
// Screen memory, cursor, colour registers and result register.
`include "text_console_cell_writer_unit_defines.svh"

module tccw_dp #(
  parameter int unsigned COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tccw_pkg::in_item_t                  in_data_i,
  input  logic                                cfg_valid_i,
  input  logic [tccw_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [tccw_pkg::COLOUR_W-1:0]       cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output tccw_pkg::out_item_t                 out_data_o,
  input  tccw_pkg::dp_cmd_t                   cmd_i,
  output tccw_pkg::dp_status_t                sts_o
);

  localparam int unsigned CELLS    = COLUMNS * ROWS;
  localparam int unsigned COPY_END = COLUMNS * (ROWS - 1);
  localparam int unsigned AW       = $clog2(CELLS);
  localparam int unsigned CW       = $clog2(COLUMNS);
  localparam int unsigned RW       = $clog2(ROWS);

  logic [15:0]                    cells_q [CELLS];
  logic [15:0]                    rdata_q;
  logic [CW-1:0]                  cur_col_q, cur_col_d;
  logic [RW-1:0]                  cur_row_q, cur_row_d;
  logic [tccw_pkg::COLOUR_W-1:0]  fg_q, bg_q;
  tccw_pkg::in_item_t             req_q;
  logic [AW-1:0]                  ptr_q;
  tccw_pkg::sweep_mode_e          sweep_mode_q;
  logic                           wr_pend_q;
  logic [AW-1:0]                  wr_addr_q;
  logic                           wr_blank_q;
  tccw_pkg::out_item_t            out_q, res;
  logic                           out_valid_q;

  logic                           newline, col_last, row_last, wrap, scroll_need;
  logic                           copy_sel, sweep_last, out_free, in_range;
  logic [AW-1:0]                  cur_addr, src_addr, raddr, waddr;
  logic [15:0]                    wdata, blank_cell;
  logic                           we;

  assign newline     = req_q.char_code == tccw_pkg::NEWLINE_CHAR;
  assign col_last    = cur_col_q == CW'(COLUMNS - 1);
  assign row_last    = cur_row_q == RW'(ROWS - 1);
  assign wrap        = newline || col_last;
  assign scroll_need = wrap && row_last;
  assign cur_addr    = AW'(AW'(cur_row_q) * AW'(COLUMNS) + AW'(cur_col_q));

  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    if (cmd_i.exec_put) begin
      if (wrap) begin
        cur_col_d = '0;
        if (!row_last) cur_row_d = cur_row_q + 1'b1;
      end else begin
        cur_col_d = cur_col_q + 1'b1;
      end
    end
  end

  // Sweep: read the row below, write the cell in the next cycle.
  assign src_addr   = ptr_q + AW'(COLUMNS);
  assign copy_sel   = (sweep_mode_q == tccw_pkg::SWP_SCROLL) && (ptr_q < AW'(COPY_END));
  assign sweep_last = ptr_q == AW'(CELLS - 1);
  assign blank_cell = (sweep_mode_q == tccw_pkg::SWP_INIT) ? {8'h00, tccw_pkg::BLANK_CHAR}
                                                         : {bg_q, fg_q, tccw_pkg::BLANK_CHAR};

  always_comb begin
    if (cmd_i.accept) begin
      raddr = AW'(in_data_i.cell_index);
    end else if (cmd_i.sweep_step) begin
      raddr = src_addr;
    end else begin
      // hold the read address so a stalled read keeps its data
      raddr = AW'(req_q.cell_index);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = wr_addr_q;
    wdata = wr_blank_q ? blank_cell : rdata_q;
    if (wr_pend_q) begin
      we = 1'b1;
    end else if (cmd_i.exec_put && !newline) begin
      we    = 1'b1;
      waddr = cur_addr;
      wdata = {bg_q, fg_q, req_q.char_code};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) cells_q[waddr] <= wdata;
    rdata_q <= cells_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      fg_q         <= '0;
      bg_q         <= '0;
      ptr_q        <= '0;
      sweep_mode_q <= tccw_pkg::SWP_INIT;
      wr_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          tccw_pkg::REG_FG_COLOUR: fg_q <= cfg_data_i;
          tccw_pkg::REG_BG_COLOUR: bg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.sweep_start) begin
        ptr_q        <= '0;
        sweep_mode_q <= cmd_i.sweep_mode;
      end else if (cmd_i.sweep_step) begin
        ptr_q <= sweep_last ? '0 : ptr_q + 1'b1;
      end
      wr_pend_q <= cmd_i.sweep_step;
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) req_q <= in_data_i;
    wr_addr_q  <= ptr_q;
    wr_blank_q <= !copy_sel;
    if (cmd_i.load_result) out_q <= res;
  end

  assign in_range = 32'(req_q.cell_index) < CELLS;

  always_comb begin
    res.cell_value = (req_q.func == tccw_pkg::FN_READ && in_range) ? rdata_q : '0;
    res.cursor_col = 7'(cur_col_d);
    res.cursor_row = 5'(cur_row_d);
    res.scrolled   = cmd_i.from_sweep && (req_q.func == tccw_pkg::FN_PUT);
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.func        = req_q.func;
  assign sts_o.scroll_need = scroll_need;
  assign sts_o.sweep_last  = sweep_last;
  assign sts_o.out_free    = out_free;

  `TCCW_ASSERT_ALWAYS(a_cursor_in_range, (32'(cur_col_q) < COLUMNS) && (32'(cur_row_q) < ROWS), "cursor outside screen")
  `TCCW_ASSERT_IMPLIES(a_no_write_clash, wr_pend_q, !cmd_i.exec_put, "put write clashes with sweep write")
  `TCCW_ASSERT_NEXT(a_scroll_home, cmd_i.exec_put && scroll_need, (cur_col_q == '0) && row_last, "scroll left cursor off last row")
  `TCCW_ASSERT_IMPLIES(a_load_when_free, cmd_i.load_result, out_free, "result overwrites an untaken result")

endmodule

FILE: rtl/text_console_cell_writer_unit.sv
// Top level of the text console cell writer: screen memory with cursor, put/clear/read.
// A put, read or unused command is taken in IDLE, which starts the memory read; in EXEC, once
// the output register is free, a put writes its character (not a newline) and steps the cursor,
// and the result register loads. A clear, or a put that scrolls, walks the screen through the
// single write port one cell a cycle. After reset the block blanks every cell in one pass before
// it takes its first item; configuration writes are taken at any time. A finished result waits
// in an output register while the next item is taken.
module text_console_cell_writer_unit #(
  parameter int unsigned COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tccw_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tccw_pkg::out_item_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tccw_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [tccw_pkg::COLOUR_W-1:0]     cfg_data_i
);

  tccw_pkg::dp_cmd_t    dp_cmd;
  tccw_pkg::dp_status_t dp_sts;

  assign cfg_ready_o = 1'b1;

  tccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  tccw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts)
  );

endmodule
